[hw/rtl/mbps_pkg.sv]
// Package for the masked byte pattern search block.
// Holds the register map, field widths and the beat types shared by the modules.
// No dependencies.
`default_nettype none

package mbps_pkg;

   // Width of the pattern store, window depth default and field widths
   localparam int MAX_PATTERN_DEF = 16;
   localparam int PAT_BYTES       = 16;
   localparam int LEN_W           = 5;
   localparam int OFFSET_W        = 32;
   localparam int CSR_INDEX_W     = 4;
   localparam int CSR_DATA_W      = 64;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LOW    = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_HIGH   = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WILDCARD_MASK  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH = 4'd3;

   // Configuration seen by the compare logic
   typedef struct packed {
      logic [63:0]        pattern_high;
      logic [63:0]        pattern_low;
      logic [PAT_BYTES-1:0] wildcard_mask;
      logic [LEN_W-1:0]   pattern_length;
   } cfg_type;

   // One result beat
   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
   } rsp_type;

endpackage

`default_nettype wire

[hw/rtl/mbps_csr.sv]
// Configuration registers of the masked byte pattern search block.
// Depends on mbps_pkg for the register map and cfg_type.
`default_nettype none

module mbps_csr (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_valid,
   input  wire [mbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [mbps_pkg::CSR_DATA_W-1:0]  csr_data,
   output mbps_pkg::cfg_type              cfg
);
   import mbps_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Register decode; unknown indexes leave everything unchanged
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PATTERN_LOW:    cfg_in.pattern_low    = csr_data;
            CSR_PATTERN_HIGH:   cfg_in.pattern_high   = csr_data;
            CSR_WILDCARD_MASK:  cfg_in.wildcard_mask  = csr_data[PAT_BYTES-1:0];
            CSR_PATTERN_LENGTH: cfg_in.pattern_length = csr_data[LEN_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hw/rtl/mbps_match.sv]
// Byte window, buffer byte count and masked compare of the pattern search block.
// Depends on mbps_pkg for cfg_type and rsp_type.
`default_nettype none

module mbps_match #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  mbps_pkg::cfg_type cfg,
   input  wire               in_fire,
   input  wire [7:0]         data_byte,
   input  wire               last_byte,
   output logic              res_valid,
   output mbps_pkg::rsp_type res
);
   import mbps_pkg::*;

   logic [7:0]          win_ff [MAX_PATTERN];
   logic [7:0]          win_in [MAX_PATTERN];
   logic [OFFSET_W-1:0] count_ff, count_in;
   logic                reported_ff, reported_in;

   logic [OFFSET_W-1:0]  count_next;
   logic [MAX_PATTERN-1:0] age_ok;
   logic [8*PAT_BYTES-1:0] pattern;
   logic                 len_ok;
   logic                 count_ok;
   logic                 hit;

   assign pattern = {cfg.pattern_high, cfg.pattern_low};

   // Shifted window, newest byte at age 0
   always_comb begin
      win_in[0] = data_byte;
      for (int a = 1; a < MAX_PATTERN; a++) begin
         win_in[a] = win_ff[a-1];
      end
   end

   // Saturating byte count including this beat
   assign count_next = (count_ff == {OFFSET_W{1'b1}}) ? count_ff : count_ff + 1'b1;

   // Per age compare: age a lines up with pattern position len-1-a
   always_comb begin
      logic [LEN_W-1:0] pos;
      logic [3:0]       idx;
      for (int a = 0; a < MAX_PATTERN; a++) begin
         pos = LEN_W'(cfg.pattern_length - LEN_W'(1) - LEN_W'(a));
         idx = pos[3:0];
         age_ok[a] = (LEN_W'(a) >= cfg.pattern_length) || cfg.wildcard_mask[idx] ||
                     (win_in[a] == pattern[idx*8 +: 8]);
      end
   end

   assign len_ok   = (cfg.pattern_length != '0) &&
                     (cfg.pattern_length <= LEN_W'(MAX_PATTERN));
   assign count_ok = (count_next[OFFSET_W-1:LEN_W] != '0) ||
                     (count_next[LEN_W-1:0] >= cfg.pattern_length);
   assign hit      = !reported_ff && len_ok && count_ok && (&age_ok);

   // Result for the beat being taken
   assign res_valid        = !reported_ff && (hit || last_byte);
   assign res.found        = hit;
   assign res.match_offset = hit ? count_next - OFFSET_W'(cfg.pattern_length) : '0;

   // State update; the last byte rearms the buffer
   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (in_fire) begin
         if (!reported_ff) begin
            count_in = count_next;
            if (hit) begin
               reported_in = 1'b1;
            end
         end
         if (last_byte) begin
            count_in    = '0;
            reported_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   // Window bytes are payload; the count keeps stale ones out of the compare
   always_ff @(posedge clock) begin
      if (in_fire && !reported_ff) begin
         win_ff <= win_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/mbps_rsp_buf.sv]
// Two-beat result buffer (output register plus skid) of the pattern search block.
// Depends on mbps_pkg for rsp_type.
`default_nettype none

module mbps_rsp_buf (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  mbps_pkg::rsp_type push_beat,
   output logic              not_full,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output mbps_pkg::rsp_type rsp_beat
);
   import mbps_pkg::*;

   logic [1:0] fill_ff, fill_in;
   rsp_type    head_ff, head_in;
   rsp_type    skid_ff, skid_in;
   logic       pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (fill_ff != 2'd0);
   assign not_full  = (fill_ff != 2'd2);
   assign rsp_beat  = head_ff;

   // Head holds the oldest beat, skid the one behind it
   always_comb begin
      fill_in = fill_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      case ({push, pop})
         2'b10: begin
            fill_in = fill_ff + 2'd1;
            if (fill_ff == 2'd0) begin
               head_in = push_beat;
            end else begin
               skid_in = push_beat;
            end
         end
         2'b01: begin
            fill_in = fill_ff - 2'd1;
            head_in = skid_ff;
         end
         2'b11: begin
            if (fill_ff == 2'd1) begin
               head_in = push_beat;
            end else begin
               head_in = skid_ff;
               skid_in = push_beat;
            end
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= 2'd0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

[hw/rtl/masked_byte_pattern_search.sv]
// Masked byte pattern search, top level.
// Haystack bytes arrive on req_* one per beat, req_last_byte marking the end of a
// buffer. The window of recent bytes is compared against the pattern held in the
// csr_* registers (pattern bytes, wildcard mask, length); wildcard positions match
// any byte. One rsp_* beat per buffer: found with the offset of the leftmost match
// as soon as it completes, or not-found (offset 0) at the last byte. Bytes after
// a match are dropped until the last byte, which rearms the search.
// Throughput: one byte per cycle while req_ready is high; the compare is
// combinational between the window registers and the result buffer. The result
// is registered in the result buffer before it appears on rsp_*.
// The result buffer holds two beats, so req_ready stays high while one result
// waits; it drops whenever both are full, even while the receiver takes a beat.
// csr_ready is always high; writes take effect for the next byte.
// Synchronous reset clears the csr_* registers, byte count and result buffer.
// Depends on mbps_pkg, mbps_csr, mbps_match and mbps_rsp_buf.
`default_nettype none

module masked_byte_pattern_search #(
   parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire [7:0]                       req_data_byte,
   input  wire                             req_last_byte,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output logic                            rsp_found,
   output logic [mbps_pkg::OFFSET_W-1:0]   rsp_match_offset,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [mbps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire [mbps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mbps_pkg::*;

   cfg_type cfg;
   rsp_type res;
   rsp_type rsp_beat;
   logic    res_valid;
   logic    in_fire;
   logic    not_full;

   assign csr_ready = 1'b1;
   assign req_ready = not_full;
   assign in_fire   = req_valid && req_ready;

   mbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mbps_match #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_match (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_fire   (in_fire),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   mbps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (in_fire && res_valid),
      .push_beat (res),
      .not_full  (not_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_found        = rsp_beat.found;
   assign rsp_match_offset = rsp_beat.match_offset;

endmodule

`default_nettype wire
